// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst is high. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- hdl/slotva_pkg.sv -----
// ----------------------------------------------------------------------------
// slotva_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package slotva_pkg;

  localparam int SLOTS_DEFAULT = 256;

  localparam int SLOT_IN_W = 8;
  localparam int STATE_W   = 2;
  localparam int AGE_W     = 32;
  localparam int IN_DATA_W = 48;   // 8 + 2 + 32 bits, padded to bytes
  localparam int OUT_SEL_W = 3;
  localparam int CAP_W     = 9;
  localparam int CFG_IDX_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECYCLE  = 4'd1;

  // slot state codes
  localparam logic [STATE_W-1:0] ST_DEAD     = 2'd0;
  localparam logic [STATE_W-1:0] ST_SLEEPING = 2'd2;

  typedef enum logic [OUT_SEL_W-1:0] {
    OUT_APPENDED = 3'd0,
    OUT_RECYCLED = 3'd1,
    OUT_CLIPPED  = 3'd2,
    OUT_WRITTEN  = 3'd3,
    OUT_IGNORED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic load;        // latch the accepted request
    logic scan_start;  // begin a victim search
    logic commit;      // write the table and load the result register
  } dp_cmd_t;

  typedef struct packed {
    outcome_t kind;    // what the latched request will do
    logic     scan_done;
    logic     out_free;
  } dp_stat_t;

endpackage

// ----- hdl/slotva_ctrl.sv -----
// ----------------------------------------------------------------------------
// slotva_ctrl
// Request sequencer: accept, classify, optional victim scan, commit.
// ----------------------------------------------------------------------------
module slotva_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slotva_pkg::dp_stat_t stat,
  output slotva_pkg::dp_cmd_t  cmd
);
  import slotva_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (stat.kind == OUT_RECYCLED) state <= S_SCAN;
          else state <= S_FINISH;
        end
        S_SCAN: begin
          if (stat.scan_done) state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the result register can take the request's result
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state == S_IDLE) && !rst;
  assign cmd.load       = in_ready && in_valid;
  assign cmd.scan_start = (state == S_DECIDE) && (stat.kind == OUT_RECYCLED);
  assign cmd.commit     = (state == S_FINISH) && stat.out_free;

endmodule

// ----- hdl/slotva_dp.sv -----
// ----------------------------------------------------------------------------
// slotva_dp
// Slot table memory, used count, config registers, victim scan, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slotva_dp #(
  parameter int SLOTS = slotva_pkg::SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  slotva_pkg::dp_cmd_t                cmd,
  output slotva_pkg::dp_stat_t               stat,
  input  logic                               cfg_we,
  input  logic [slotva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slotva_pkg::CAP_W-1:0]       cfg_data,
  input  logic                               in_req_type,
  input  logic [slotva_pkg::SLOT_IN_W-1:0]   in_slot_index,
  input  logic [slotva_pkg::STATE_W-1:0]     in_entry_state,
  input  logic [slotva_pkg::AGE_W-1:0]       in_entry_age,
  output logic                               out_valid,
  input  logic                               out_ready,
  output slotva_pkg::outcome_t               out_outcome,
  output logic [slotva_pkg::SLOT_IN_W-1:0]   out_chosen_slot
);
  import slotva_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int MEM_W = STATE_W + AGE_W;

  // configuration
  logic [CAP_W-1:0] capacity;
  logic             recycle_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RESET;
      recycle_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY: capacity       <= cfg_data;
        REG_RECYCLE:  recycle_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched request
  logic                 req_type;
  logic [SLOT_IN_W-1:0] slot_index;
  logic [STATE_W-1:0]   entry_state;
  logic [AGE_W-1:0]     entry_age;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type    <= in_req_type;
      slot_index  <= in_slot_index;
      entry_state <= in_entry_state;
      entry_age   <= in_entry_age;
    end
  end

  logic [CNT_W-1:0] used_count;

  // classify the latched request
  logic [CMP_W-1:0] n_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] eff_cap;
  outcome_t         kind;

  always_comb begin
    n_ext   = CMP_W'(used_count);
    idx_ext = CMP_W'(slot_index);
    eff_cap = CMP_W'(capacity);
    if (capacity == '0) eff_cap = CMP_W'(1);
    if (eff_cap > CMP_W'(SLOTS)) eff_cap = CMP_W'(SLOTS);
    if (req_type) begin
      kind = (idx_ext < n_ext) ? OUT_WRITTEN : OUT_IGNORED;
    end else if (n_ext < eff_cap) begin
      kind = OUT_APPENDED;
    end else if (!recycle_enable || used_count == '0) begin
      kind = OUT_CLIPPED;
    end else begin
      kind = OUT_RECYCLED;
    end
  end

  // victim scan: one table read per cycle, read data registered for the next cycle
  logic [MEM_W-1:0] mem [SLOTS];
  logic [MEM_W-1:0] rd_data;
  logic [CNT_W-1:0] scan_addr;
  logic             scan_busy;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             scan_done;

  logic             dead_found;
  logic [IDX_W-1:0] dead_idx;
  logic             slp_found;
  logic [IDX_W-1:0] slp_idx;
  logic [AGE_W-1:0] slp_age;
  logic             any_found;
  logic [IDX_W-1:0] any_idx;
  logic [AGE_W-1:0] any_age;

  logic [STATE_W-1:0] rd_state;
  logic [AGE_W-1:0]   rd_age;

  assign rd_state  = rd_data[MEM_W-1:AGE_W];
  assign rd_age    = rd_data[AGE_W-1:0];
  assign scan_done = scan_busy && (scan_addr == used_count) && !rd_pend;

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      rd_pend   <= 1'b0;
      scan_addr <= '0;
    end else if (cmd.scan_start) begin
      scan_busy <= 1'b1;
      rd_pend   <= 1'b0;
      scan_addr <= '0;
    end else if (scan_busy) begin
      if (scan_addr != used_count) begin
        rd_pend   <= 1'b1;
        scan_addr <= scan_addr + 1'b1;
      end else begin
        rd_pend <= 1'b0;
      end
      if (scan_done) scan_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_addr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      dead_found <= 1'b0;
      slp_found  <= 1'b0;
      any_found  <= 1'b0;
    end else if (rd_pend) begin
      // first dead slot wins outright
      if (rd_state == ST_DEAD && !dead_found) begin
        dead_found <= 1'b1;
        dead_idx   <= rd_idx;
      end
      // strict compare keeps the lowest index on equal ages
      if (rd_state == ST_SLEEPING && (!slp_found || rd_age > slp_age)) begin
        slp_found <= 1'b1;
        slp_idx   <= rd_idx;
        slp_age   <= rd_age;
      end
      if (!any_found || rd_age > any_age) begin
        any_found <= 1'b1;
        any_idx   <= rd_idx;
        any_age   <= rd_age;
      end
    end
  end

  logic [IDX_W-1:0] victim;
  logic [IDX_W-1:0] slot_sel;
  logic             table_we;

  always_comb begin
    if (dead_found)     victim = dead_idx;
    else if (slp_found) victim = slp_idx;
    else                victim = any_idx;
    case (kind)
      OUT_WRITTEN:  slot_sel = idx_ext[IDX_W-1:0];
      OUT_APPENDED: slot_sel = n_ext[IDX_W-1:0];
      OUT_RECYCLED: slot_sel = victim;
      default:      slot_sel = '0;
    endcase
    table_we = cmd.commit &&
               (kind == OUT_WRITTEN || kind == OUT_APPENDED || kind == OUT_RECYCLED);
  end

  always_ff @(posedge clk) begin
    if (table_we) mem[slot_sel] <= {entry_state, entry_age};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.commit && kind == OUT_APPENDED) begin
      used_count <= used_count + 1'b1;
    end
  end

  // result register
  logic [CMP_W-1:0] slot_ext;
  assign slot_ext = CMP_W'(slot_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome     <= kind;
      out_chosen_slot <= slot_ext[SLOT_IN_W-1:0];
    end
  end

  assign stat.kind      = kind;
  assign stat.scan_done = scan_done;
  assign stat.out_free  = !out_valid || out_ready;

  `ASSERT_NEVER(a_used_bound, CMP_W'(used_count) > CMP_W'(SLOTS))
  `ASSERT_PROP(a_victim_in_use, (cmd.commit && kind == OUT_RECYCLED) |-> (CMP_W'(victim) < n_ext))
  `ASSERT_PROP(a_commit_free, cmd.commit |-> (!out_valid || out_ready))

endmodule

// ----- hdl/slot_victim_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_victim_allocator
// Slot table with append, in-place write and victim recycling on spawn.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Appends, writes, clipped spawns and
// ignored writes pass through a decide state to a finish state, which
// loads the output register and raises m_tvalid. A recycling spawn first
// scans the slot table through its single read port, one in-use slot per
// cycle, between those states. The next request is accepted as soon as the
// previous result sits in the output register, even if it has not been
// taken yet. Configuration writes are ready whenever reset is low and take
// effect on the next cycle; there is no clearing pass after reset.
module slot_victim_allocator #(
  parameter int SLOTS = slotva_pkg::SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // request
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [slotva_pkg::IN_DATA_W-1:0]   s_tdata,  // slot_index, entry_state, entry_age
  input  logic                               s_tuser,  // req_type
  // result
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [slotva_pkg::SLOT_IN_W-1:0]   m_tdata,  // chosen_slot
  output logic [slotva_pkg::OUT_SEL_W-1:0]   m_tuser,  // outcome
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [slotva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slotva_pkg::CAP_W-1:0]       cfg_data
);
  import slotva_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  outcome_t outcome;

  assign cfg_ready = !rst;

  slotva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slotva_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_req_type     (s_tuser),
    .in_slot_index   (s_tdata[SLOT_IN_W-1:0]),
    .in_entry_state  (s_tdata[SLOT_IN_W+STATE_W-1:SLOT_IN_W]),
    .in_entry_age    (s_tdata[SLOT_IN_W+STATE_W+AGE_W-1:SLOT_IN_W+STATE_W]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_outcome     (outcome),
    .out_chosen_slot (m_tdata)
  );

  assign m_tuser = outcome;

endmodule

// ----- bench/slot_victim_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// slot_victim_allocator_tb
// Self-checking bench for the slot allocator. A directed table covers capacity
// clamping, clipping, dead and sleeping victims, ignored writes. Random spawn
// and write requests then run over several capacity and recycle settings. Each
// result is compared in order against a behavioral model of the slot table.
// ----------------------------------------------------------------------------
module slot_victim_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slotva_pkg::*;

  localparam int SLOTS       = SLOTS_DEFAULT;
  localparam int PERIOD      = 10;
  localparam int LIMIT       = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;

  localparam logic [STATE_W-1:0] ST_ACTIVE = 2'd1;
  localparam logic [STATE_W-1:0] ST_ODD    = 2'd3;  // unnamed code, acts as active

  typedef enum logic {REQ_SPAWN = 1'b0, REQ_WRITE = 1'b1} req_kind_t;
  typedef enum logic [1:0] {ROW_SPAWN, ROW_WRITE, ROW_CAP, ROW_RECYCLE} row_kind_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [SLOT_IN_W-1:0] slot;
  } slot_result_t;

  // config rows carry the register value in age
  typedef struct packed {
    row_kind_t            kind;
    logic [SLOT_IN_W-1:0] idx;
    logic [STATE_W-1:0]   st;
    logic [AGE_W-1:0]     age;
    logic                 typed;
    slot_result_t         want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata;   // slot_index, entry_state, entry_age, zero pad
  logic                 s_tuser;   // req_type
  logic                 m_tvalid;
  logic                 m_tready;
  logic [SLOT_IN_W-1:0] m_tdata;   // chosen_slot
  logic [OUT_SEL_W-1:0] m_tuser;   // outcome
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CAP_W-1:0]     cfg_data;

  // model of the slot table
  logic [STATE_W-1:0] model_state [SLOTS];
  logic [AGE_W-1:0]   model_age   [SLOTS];
  int unsigned        used_slots;
  logic [CAP_W-1:0]   cap_reg;
  logic               recycle_on;

  slot_result_t pending_results[$];
  plan_row_t    plan[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  bit           steady;
  bit           hold_req;

  always #(PERIOD/2) clk = ~clk;

  slot_victim_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic plan_row_t row(row_kind_t kind, logic [7:0] idx, logic [1:0] st,
                                    logic [31:0] age, logic typed, outcome_t oc,
                                    logic [7:0] slot);
    plan_row_t r;
    r.kind = kind;
    r.idx = idx;
    r.st = st;
    r.age = age;
    r.typed = typed;
    r.want.outcome = oc;
    r.want.slot = slot;
    return r;
  endfunction

  // apply one request to the model and return what the block should report
  task automatic allocate_slot(input req_kind_t req, input logic [7:0] idx,
                               input logic [1:0] st, input logic [31:0] age,
                               output slot_result_t res);
    int unsigned n;
    int unsigned lim;
    int unsigned pick;
    bit          found;
    logic [31:0] best_age;
    n = used_slots;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
    res.slot = '0;
    if (req == REQ_WRITE) begin
      if (idx < n) begin
        model_state[idx] = st;
        model_age[idx] = age;
        res.outcome = OUT_WRITTEN;
        res.slot = idx;
      end else begin
        res.outcome = OUT_IGNORED;
      end
    end else if (n < lim) begin
      model_state[n] = st;
      model_age[n] = age;
      used_slots = n + 1;
      res.outcome = OUT_APPENDED;
      res.slot = n[7:0];
    end else if (!recycle_on || n == 0) begin
      res.outcome = OUT_CLIPPED;
    end else begin
      found = 0;
      pick = 0;
      best_age = '0;
      // first dead slot wins outright
      for (int i = 0; i < n && !found; i++)
        if (model_state[i] == ST_DEAD) begin
          found = 1;
          pick = i;
        end
      // then the oldest sleeping slot, lowest index on a tie
      if (!found)
        for (int i = 0; i < n; i++)
          if (model_state[i] == ST_SLEEPING && (!found || model_age[i] > best_age)) begin
            found = 1;
            best_age = model_age[i];
            pick = i;
          end
      // then the oldest slot of any state
      if (!found)
        for (int i = 0; i < n; i++)
          if (!found || model_age[i] > best_age) begin
            found = 1;
            best_age = model_age[i];
            pick = i;
          end
      model_state[pick] = st;
      model_age[pick] = age;
      res.outcome = OUT_RECYCLED;
      res.slot = pick[7:0];
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // caller stands at a falling edge; returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CAPACITY) cap_reg = value;
    else recycle_on = value[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // caller stands at a falling edge; returns at a falling edge
  task automatic offer(input req_kind_t req, input logic [7:0] idx, input logic [1:0] st,
                       input logic [31:0] age, input logic typed,
                       input slot_result_t typed_res);
    slot_result_t res;
    s_tvalid = 1'b1;
    s_tuser = req;
    s_tdata = '0;
    s_tdata[7:0] = idx;
    s_tdata[9:8] = st;
    s_tdata[41:10] = age;
    do @(posedge clk); while (!s_tready);
    allocate_slot(req, idx, st, age, res);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (!steady && $urandom_range(0, 99) < 24) @(negedge clk);
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      m_tready = steady || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: outcome %0d chosen_slot %0d", m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, m_tuser);
          mismatches++;
        end
        if (m_tdata !== want.slot) begin
          $error("chosen_slot: expected %0d, got %0d", want.slot, m_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          phase_cap [PHASES];
    int          phase_rec [PHASES];
    int          phase_len [PHASES];
    plan_row_t   r;
    req_kind_t   req;
    logic [7:0]  idx;
    logic [1:0]  st;
    logic [31:0] age;

    phase_cap = '{3, 1, 16, 16, 5, 40, 256, 300};
    phase_rec = '{1, 1, 0, 1, 1, 1, 1, 0};
    phase_len = '{150, 100, 150, 300, 200, 300, 450, 200};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CAPACITY;
    cfg_data = '0;
    steady = 0;
    hold_req = 0;
    used_slots = 0;
    cap_reg = CAP_RESET;
    recycle_on = 1'b1;

    //                         kind         idx  state        age           typed outcome  slot
    plan.insert(plan.size(), row(ROW_WRITE,   0,   ST_ACTIVE,   32'd9,        1, OUT_IGNORED,  0));
    plan.insert(plan.size(), row(ROW_CAP,     0,   0,           32'd0,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_SLEEPING, 32'hFFFFFFFF, 1, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ACTIVE,   32'd5,        1, OUT_RECYCLED, 0));
    plan.insert(plan.size(), row(ROW_RECYCLE, 0,   0,           32'd0,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ACTIVE,   32'd6,        1, OUT_CLIPPED,  0));
    plan.insert(plan.size(), row(ROW_WRITE,   0,   ST_DEAD,     32'd0,        1, OUT_WRITTEN,  0));
    plan.insert(plan.size(), row(ROW_CAP,     0,   0,           32'd4,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_RECYCLE, 0,   0,           32'd1,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   255, ST_ACTIVE,   32'd10,       1, OUT_APPENDED, 1));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ODD,      32'd0,        1, OUT_APPENDED, 2));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_SLEEPING, 32'd7,        1, OUT_APPENDED, 3));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ACTIVE,   32'd1,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_DEAD,     32'hFFFFFFFF, 0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ACTIVE,   32'd3,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_WRITE,   1,   ST_SLEEPING, 32'd20,       0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_WRITE,   2,   ST_SLEEPING, 32'd20,       0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ACTIVE,   32'd0,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_WRITE,   4,   ST_ACTIVE,   32'd1,        1, OUT_IGNORED,  0));
    plan.insert(plan.size(), row(ROW_CAP,     0,   0,           32'd2,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_SLEEPING, 32'd2,        0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_CAP,     0,   0,           32'd511,      0, OUT_APPENDED, 0));
    plan.insert(plan.size(), row(ROW_SPAWN,   0,   ST_ACTIVE,   32'hFF,       1, OUT_APPENDED, 4));
    plan.insert(plan.size(), row(ROW_WRITE,   255, ST_ODD,      32'hFFFFFFFF, 1, OUT_IGNORED,  0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      r = plan[i];
      case (r.kind)
        ROW_CAP:     write_reg(REG_CAPACITY, r.age[8:0]);
        ROW_RECYCLE: write_reg(REG_RECYCLE, r.age[8:0]);
        default:     offer(r.kind == ROW_WRITE ? REQ_WRITE : REQ_SPAWN,
                           r.idx, r.st, r.age, r.typed, r.want);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_CAPACITY, CAP_W'(phase_cap[p]));
      write_reg(REG_RECYCLE, CAP_W'(phase_rec[p]));
      steady = (p == 3);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < phase_len[p]; k++) begin
        // pause until the block has handed back everything
        if (p == 4 && k == 100) wait_drained();
        req = ($urandom_range(0, 99) < 60) ? REQ_SPAWN : REQ_WRITE;
        if (used_slots > 0 && $urandom_range(0, 99) < 85)
          idx = 8'($urandom_range(0, used_slots - 1));
        else
          idx = 8'($urandom_range(0, 255));
        st = 2'($urandom_range(0, 3));
        // small ages force ties between slots
        case ($urandom_range(0, 9))
          0, 1, 2: age = $urandom_range(0, 7);
          3:       age = 32'hFFFFFFFF;
          4:       age = 32'd0;
          default: age = $urandom;
        endcase
        offer(req, idx, st, age, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SLOTS + 20) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
